@@ rtl/core/fcr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flag CRC frame receiver package
// Shared constants, status codes and the control word of the serial CRC unit.
// ----------------------------------------------------------------------------
package fcr_pkg;

    // Frame store geometry.
    localparam int STORE_BYTES = 64;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int CNT_W       = $clog2(STORE_BYTES + 1);

    // Byte and CRC constants.
    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h1021;

    // Status codes carried in the low bits of the result tuser.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_OVERFLOW = 3'd1;
    localparam logic [2:0] ST_OUTSIDE  = 3'd2;
    localparam logic [2:0] ST_SHORT    = 3'd3;
    localparam logic [2:0] ST_CRC      = 3'd4;

    // Control word from the frame sequencer to the serial CRC unit.
    typedef struct packed {
        logic init;   // reload the accumulator with the initial value
        logic start;  // begin folding one byte, most significant bit first
    } crc_ctl_t;

endpackage

@@ rtl/core/flag_crc_frame_receiver.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flag CRC frame receiver
// Collects flag-delimited frames, checks a CRC-16 and delivers good payloads.
// ----------------------------------------------------------------------------
// Each input word is one received byte. A frame is 0x7E, payload, CRC high,
// CRC low, 0x7E; the CRC is CRC-16 with poly 0x1021, init 0xFFFF, no
// reflection, taken over the payload. Every byte gives one status word,
// except a closing flag of a good frame, which gives one word per payload
// byte (or a single word for an empty payload) with tlast on the final one.
// Timing: each payload byte is folded by the bit-serial CRC unit, which folds
// one bit per cycle while the next byte waits; a good frame is then read out
// of the 64-byte store one payload byte at a time, through S_READ and S_PUSH.
// Input words are taken while a result still waits in the output register.
// The store needs no clearing after reset.
// ----------------------------------------------------------------------------
module flag_crc_frame_receiver (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] payload_byte
    output logic [4:0] m_tuser,   // [2:0] status, [3] frame_good, [4] payload_valid
    output logic       m_tlast    // last word caused by this input byte
);
    import fcr_pkg::*;

    // Sequencer states.
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_READ   = 2'd2;
    localparam logic [1:0] S_PUSH   = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic              in_frame_reg, in_frame_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] pay_idx_reg, pay_idx_next;
    logic [7:0]        rx_reg, rx_next;
    logic [7:0]        last1_reg, last1_next;
    logic [7:0]        last2_reg, last2_next;

    logic              m_valid_reg, m_valid_next;
    logic [2:0]        m_status_reg, m_status_next;
    logic              m_good_reg, m_good_next;
    logic              m_pv_reg, m_pv_next;
    logic [7:0]        m_byte_reg, m_byte_next;
    logic              m_last_reg, m_last_next;

    crc_ctl_t          crc_ctl;
    logic              crc_busy;
    logic [15:0]       crc_value;

    logic              wr_en;
    logic [7:0]        rd_data;
    logic              out_free;
    logic              is_flag;
    logic [CNT_W-1:0]  plen_full;
    logic [ADDR_W-1:0] plen;
    logic              pay_last;

    // Bit-serial CRC over payload bytes.
    fcr_crc_serial u_crc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (crc_ctl),
        .data    (last2_reg),
        .busy    (crc_busy),
        .crc     (crc_value)
    );

    // Frame store; payload reads follow the delivery index.
    fcr_store u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (rx_reg),
        .rd_addr (pay_idx_reg),
        .rd_data (rd_data)
    );

    assign out_free  = !m_valid_reg || m_tready;
    assign is_flag   = (rx_reg == FLAG_BYTE);
    assign plen_full = count_reg - CNT_W'(3);
    assign plen      = plen_full[ADDR_W-1:0];
    assign pay_last  = (pay_idx_reg == plen);

    // Frame sequencer: classify each byte, update the frame state, load results.
    always_comb begin
        state_next    = state_reg;
        in_frame_next = in_frame_reg;
        count_next    = count_reg;
        pay_idx_next  = pay_idx_reg;
        rx_next       = rx_reg;
        last1_next    = last1_reg;
        last2_next    = last2_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_good_next   = m_good_reg;
        m_pv_next     = m_pv_reg;
        m_byte_next   = m_byte_reg;
        m_last_next   = m_last_reg;
        crc_ctl       = '0;
        wr_en         = 1'b0;
        s_tready      = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    rx_next    = s_tdata;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!crc_busy && out_free) begin
                    // Default result: a single status word.
                    m_valid_next  = 1'b1;
                    m_status_next = ST_OK;
                    m_good_next   = 1'b0;
                    m_pv_next     = 1'b0;
                    m_byte_next   = 8'h00;
                    m_last_next   = 1'b1;
                    state_next    = S_IDLE;
                    priority if (count_reg == CNT_W'(STORE_BYTES)) begin
                        // Store full: drop the byte and start over.
                        m_status_next = ST_OVERFLOW;
                        in_frame_next = 1'b0;
                        count_next    = '0;
                        crc_ctl.init  = 1'b1;
                    end else if (is_flag && !in_frame_reg) begin
                        // Opening flag.
                        crc_ctl.init  = 1'b1;
                        in_frame_next = 1'b1;
                        count_next    = CNT_W'(1);
                        last1_next    = rx_reg;
                    end else if (!in_frame_reg) begin
                        m_status_next = ST_OUTSIDE;
                    end else if (!is_flag) begin
                        // The byte two back is now known to be payload.
                        if (count_reg >= CNT_W'(3)) begin
                            crc_ctl.start = 1'b1;
                        end
                        wr_en      = 1'b1;
                        last2_next = last1_reg;
                        last1_next = rx_reg;
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        // Closing flag.
                        in_frame_next = 1'b0;
                        if (count_reg < CNT_W'(3)) begin
                            m_status_next = ST_SHORT;
                        end else if ({last2_reg, last1_reg} != crc_value) begin
                            m_status_next = ST_CRC;
                        end else if (count_reg == CNT_W'(3)) begin
                            // Good frame with an empty payload.
                            m_good_next  = 1'b1;
                            count_next   = '0;
                            crc_ctl.init = 1'b1;
                        end else begin
                            m_valid_next = m_valid_reg && !m_tready;
                            pay_idx_next = ADDR_W'(1);
                            state_next   = S_READ;
                        end
                    end
                end
            end
            S_READ: begin
                state_next = S_PUSH;
            end
            S_PUSH: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = ST_OK;
                    m_good_next   = 1'b1;
                    m_pv_next     = 1'b1;
                    m_byte_next   = rd_data;
                    m_last_next   = pay_last;
                    if (pay_last) begin
                        count_next   = '0;
                        crc_ctl.init = 1'b1;
                        state_next   = S_IDLE;
                    end else begin
                        pay_idx_next = pay_idx_reg + ADDR_W'(1);
                        state_next   = S_READ;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            in_frame_reg <= 1'b0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            in_frame_reg <= in_frame_next;
            count_reg    <= count_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        pay_idx_reg  <= pay_idx_next;
        rx_reg       <= rx_next;
        last1_reg    <= last1_next;
        last2_reg    <= last2_next;
        m_status_reg <= m_status_next;
        m_good_reg   <= m_good_next;
        m_pv_reg     <= m_pv_next;
        m_byte_reg   <= m_byte_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tuser  = {m_pv_reg, m_good_reg, m_status_reg};
    assign m_tlast  = m_last_reg;

    // The frame count never runs past the store size.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STORE_BYTES))
        else $error("frame count exceeds store size");

    // An open frame always holds at least its opening flag.
    a_open_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        in_frame_reg |-> (count_reg != '0))
        else $error("open frame with zero count");

    // No byte is classified while the CRC unit is still folding.
    a_wait_crc: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DECIDE) && crc_busy |=> (state_reg == S_DECIDE))
        else $error("byte classified during CRC update");

    // Payload words only come from a checked frame with status ok.
    a_payload_good: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_pv_reg |-> m_good_reg && (m_status_reg == ST_OK))
        else $error("payload word outside a good frame");

endmodule

@@ rtl/core/fcr_crc_serial.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial CRC-16 unit
// Folds one byte into a CRC-16 (poly 0x1021, no reflection) one bit per cycle.
// ----------------------------------------------------------------------------
module fcr_crc_serial (
    input  logic              aclk,
    input  logic              aresetn,
    input  fcr_pkg::crc_ctl_t ctl,
    input  logic [7:0]        data,
    output logic              busy,
    output logic [15:0]       crc
);
    import fcr_pkg::*;

    logic [15:0] crc_reg, crc_next;
    logic [7:0]  shift_reg, shift_next;
    logic [2:0]  bit_cnt_reg, bit_cnt_next;
    logic        busy_reg, busy_next;
    logic        feedback;

    // One bit step of the CRC shift register, and the load and init controls.
    always_comb begin
        crc_next     = crc_reg;
        shift_next   = shift_reg;
        bit_cnt_next = bit_cnt_reg;
        busy_next    = busy_reg;
        feedback     = crc_reg[15] ^ shift_reg[7];
        if (ctl.init) begin
            crc_next  = CRC_INIT;
            busy_next = 1'b0;
        end else if (ctl.start) begin
            shift_next   = data;
            bit_cnt_next = 3'd0;
            busy_next    = 1'b1;
        end else if (busy_reg) begin
            crc_next     = {crc_reg[14:0], 1'b0} ^ (feedback ? CRC_POLY : 16'h0000);
            shift_next   = {shift_reg[6:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + 3'd1;
            if (bit_cnt_reg == 3'd7) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg     <= CRC_INIT;
            bit_cnt_reg <= 3'd0;
            busy_reg    <= 1'b0;
        end else begin
            crc_reg     <= crc_next;
            bit_cnt_reg <= bit_cnt_next;
            busy_reg    <= busy_next;
        end
    end

    // The data shift register carries payload only.
    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
    end

    assign busy = busy_reg;
    assign crc  = crc_reg;

endmodule

@@ rtl/core/fcr_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame byte store
// Single-port-write, registered-read memory that holds the frame being received.
// ----------------------------------------------------------------------------
module fcr_store (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [fcr_pkg::ADDR_W-1:0] wr_addr,
    input  logic [7:0]                wr_data,
    input  logic [fcr_pkg::ADDR_W-1:0] rd_addr,
    output logic [7:0]                rd_data
);
    import fcr_pkg::*;

    logic [7:0] mem [STORE_BYTES];
    logic [7:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
